[hw/rtl/sbox_tea_block_decrypt_unit_assert.svh]
// Assertion macros for the S-box TEA block decryptor.
`ifndef SBOX_TEA_BLOCK_DECRYPT_UNIT_ASSERT_SVH
`define SBOX_TEA_BLOCK_DECRYPT_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define SBTD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sbtd check failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define SBTD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sbtd check failed");

`endif

[hw/rtl/sbtd_pkg.sv]
// Shared types and constants for the S-box TEA block decryptor.
package sbtd_pkg;

  localparam int BLOCK_W        = 64;
  localparam int WORD_W         = 32;
  localparam int KEY_W          = 8;
  localparam int SHIFT_W        = 5;
  localparam int SBOX_AW        = 8;
  localparam int SBOX_DEPTH     = 1 << SBOX_AW;
  localparam int ROUNDS_DEFAULT = 1145;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_KSA_J,
    ST_KSA_I,
    ST_PRIME,
    ST_RND_Y,
    ST_RND_X
  } state_t;

endpackage

[hw/rtl/sbox_tea_block_decrypt_unit.sv]
// Top level of the S-box TEA block decryptor: sequencer, S-box RAM and round unit.
//
// One item (a 64-bit ciphertext block plus its key bytes, shift amounts and
// delta) is taken when start is high and busy is low. The block then stays
// busy while it fills the 256x8 S-box RAM with the identity, runs the key
// schedule with each swap split over the KSA_J and KSA_I states (the RAM's
// single write port sets that pace), fetches the first S-box entry, and runs
// each round on one shared round unit (second half, then first half). The
// plaintext appears on plain_block for exactly one cycle with done high,
// in the cycle in which busy falls; the receiver cannot stall it, so capture
// it then. A new item may be started in that same cycle. The S-box is
// rebuilt for every item, so nothing carries over from one item to the next.
`include "sbox_tea_block_decrypt_unit_assert.svh"

module sbox_tea_block_decrypt_unit #(
  parameter int ROUNDS = sbtd_pkg::ROUNDS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [sbtd_pkg::BLOCK_W-1:0] cipher_block,
  input  logic [sbtd_pkg::KEY_W-1:0]   key_word_0,
  input  logic [sbtd_pkg::KEY_W-1:0]   key_word_1,
  input  logic [sbtd_pkg::KEY_W-1:0]   key_word_2,
  input  logic [sbtd_pkg::KEY_W-1:0]   key_word_3,
  input  logic [sbtd_pkg::SHIFT_W-1:0] shift_0,
  input  logic [sbtd_pkg::SHIFT_W-1:0] shift_1,
  input  logic [sbtd_pkg::SHIFT_W-1:0] shift_2,
  input  logic [sbtd_pkg::SHIFT_W-1:0] shift_3,
  input  logic [sbtd_pkg::WORD_W-1:0]  round_delta,
  output logic                         done,
  output logic [sbtd_pkg::BLOCK_W-1:0] plain_block
);
  import sbtd_pkg::*;

  localparam int RCW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam logic [RCW-1:0]    LAST_RND = RCW'(ROUNDS - 1);
  localparam logic [WORD_W-1:0] ROUNDS_K = WORD_W'(ROUNDS);
  localparam logic [SBOX_AW-1:0] LAST_IDX = SBOX_AW'(SBOX_DEPTH - 1);

  state_t state, state_next;

  // S-box RAM: one write port, one registered read port
  logic [KEY_W-1:0]   sbox [SBOX_DEPTH];
  logic [KEY_W-1:0]   rd;
  logic               mem_we;
  logic [SBOX_AW-1:0] mem_wa;
  logic [KEY_W-1:0]   mem_wd;
  logic [SBOX_AW-1:0] mem_ra;

  // copy of the four lowest S-box entries, read by the first-half update
  logic [KEY_W-1:0]   sbox_low [4];

  // item context
  logic [WORD_W-1:0]  x;
  logic [WORD_W-1:0]  y;
  logic [WORD_W-1:0]  s;
  logic [WORD_W-1:0]  delta;
  logic [KEY_W-1:0]   key [4];
  logic [SHIFT_W-1:0] sh0, sh1, sh2, sh3;

  // sequencer counters
  logic [SBOX_AW-1:0] idx;
  logic [SBOX_AW-1:0] j;
  logic [SBOX_AW-1:0] jn;
  logic [RCW-1:0]     rnd_cnt;
  logic               rnd_last;

  // shared round unit
  logic [WORD_W-1:0]  u_t, u_v, u_f, u_k, u_out;
  logic [SHIFT_W-1:0] u_rsh, u_lsh;
  logic [KEY_W-1:0]   u_sb;

  assign busy     = (state != ST_IDLE);
  assign rnd_last = (rnd_cnt == LAST_RND);
  assign jn       = j + rd + key[idx[1:0]];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (start) state_next = ST_FILL;
      ST_FILL:  if (idx == LAST_IDX) state_next = ST_KSA_J;
      ST_KSA_J: state_next = ST_KSA_I;
      ST_KSA_I: state_next = (idx == LAST_IDX) ? ST_PRIME : ST_KSA_J;
      ST_PRIME: state_next = ST_RND_Y;
      ST_RND_Y: state_next = ST_RND_X;
      ST_RND_X: if (rnd_last) state_next = ST_IDLE;
                else state_next = ST_RND_Y;
      default:  state_next = ST_IDLE;
    endcase
  end

  // RAM port control
  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx;
    mem_wd = rd;
    mem_ra = s[18:11];
    case (state)
      ST_FILL: begin
        // write the identity; keep reading entry 0 so it is ready for the schedule
        mem_we = 1'b1;
        mem_wd = idx;
        mem_ra = '0;
      end
      ST_KSA_J: begin
        // rd holds S[i]: store it at j and fetch the old S[j] in the same cycle
        mem_we = 1'b1;
        mem_wa = jn;
        mem_wd = rd;
        mem_ra = jn;
      end
      ST_KSA_I: begin
        // rd holds the old S[j]: store it at i and fetch S[i+1]
        mem_we = 1'b1;
        mem_wa = idx;
        mem_wd = rd;
        mem_ra = idx + SBOX_AW'(1);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // round unit: t - ((((v >> r) ^ (v << l)) + v) ^ (sbox + s))
  always_comb begin
    if (state == ST_RND_X) begin
      u_t   = x;
      u_v   = y;
      u_rsh = sh1;
      u_lsh = sh0;
      u_sb  = sbox_low[s[1:0]];
    end else begin
      u_t   = y;
      u_v   = x;
      u_rsh = sh2;
      u_lsh = sh3;
      u_sb  = rd;
    end
    u_f   = ((u_v >> u_rsh) ^ (u_v << u_lsh)) + u_v;
    u_k   = {{(WORD_W - KEY_W){1'b0}}, u_sb} + s;
    u_out = u_t - (u_f ^ u_k);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      sbox[mem_wa] <= mem_wd;
    end
    rd <= sbox[mem_ra];
  end

  // mirror every write that lands in the four lowest entries
  always_ff @(posedge clk) begin
    if (mem_we && (mem_wa[SBOX_AW-1:2] == '0)) begin
      sbox_low[mem_wa[1:0]] <= mem_wd;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_RND_X) && rnd_last;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          x      <= cipher_block[WORD_W-1:0];
          y      <= cipher_block[BLOCK_W-1:WORD_W];
          key[0] <= key_word_0;
          key[1] <= key_word_1;
          key[2] <= key_word_2;
          key[3] <= key_word_3;
          sh0    <= shift_0;
          sh1    <= shift_1;
          sh2    <= shift_2;
          sh3    <= shift_3;
          delta  <= round_delta;
          idx    <= '0;
        end
      end
      ST_FILL: begin
        idx <= idx + SBOX_AW'(1);
        j   <= '0;
        s   <= delta * ROUNDS_K;
      end
      ST_KSA_J: begin
        j <= jn;
      end
      ST_KSA_I: begin
        idx <= idx + SBOX_AW'(1);
      end
      ST_PRIME: begin
        rnd_cnt <= '0;
      end
      ST_RND_Y: begin
        y <= u_out;
        s <= s - delta;
      end
      ST_RND_X: begin
        x       <= u_out;
        rnd_cnt <= rnd_cnt + RCW'(1);
        if (rnd_last) begin
          plain_block <= {y, u_out};
        end
      end
      default: begin
        idx <= idx;
      end
    endcase
  end

  `SBTD_ASSERT_NXT(a_start_fills, start && !busy, state == ST_FILL)
  `SBTD_ASSERT_IMP(a_done_idle, done, state == ST_IDLE)
  `SBTD_ASSERT_NXT(a_last_round_done, (state == ST_RND_X) && rnd_last, done && !busy)
  `SBTD_ASSERT_NXT(a_done_single, done, !done)
  `SBTD_ASSERT_NXT(a_swap_pairs, state == ST_KSA_J, state == ST_KSA_I)

endmodule
